>>> rtl/srs_pkg.sv
`timescale 1ns / 1ps
package srs_pkg;
	localparam int LINE_DEPTH_DEF  = 4096;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int CHANNELS_DEF    = 2;
	localparam int AP_LINES  = 3;
	localparam int CF_LINES  = 4;
	localparam int ALL_LINES = 7;
	localparam int GAIN_W    = 15;
	localparam int DLY_W     = 10;
	localparam int SPREAD_W  = 16;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd22938;

	typedef enum logic [1:0] {
		REG_GAIN   = 2'd0,
		REG_DELAY  = 2'd1,
		REG_SPREAD = 2'd2
	} reg_idx_t;

	function automatic logic [11:0] line_base(input int k);
		case (k)
			0: line_base = 12'd347;
			1: line_base = 12'd113;
			2: line_base = 12'd37;
			3: line_base = 12'd1687;
			4: line_base = 12'd1601;
			5: line_base = 12'd2053;
			6: line_base = 12'd2251;
			default: line_base = 12'd0;
		endcase
	endfunction

	function automatic logic [3:0] line_mult(input int k);
		case (k)
			1: line_mult = 4'd1;
			2: line_mult = 4'd3;
			3: line_mult = 4'd5;
			4: line_mult = 4'd7;
			5: line_mult = 4'd11;
			6: line_mult = 4'd13;
			default: line_mult = 4'd0;
		endcase
	endfunction
endpackage

>>> rtl/schroeder_reverb_stereo_top.sv
`timescale 1ns / 1ps
// Stereo Schroeder reverb: three series allpass stages and four parallel
// feed-forward comb taps, one 24-bit sample per beat tagged with its channel.
// Each of the seven delay lines is its own memory; a sample is read from, then
// written to, each line, and a new beat can enter while earlier ones are in later
// lines. After reset the block zeroes all CHANNELS*LINE_DEPTH entries (8192 by
// default) of its delay memories before any sample enters them. Delay settings
// take effect via the config, D*F product and per-line delay registers.
module schroeder_reverb_stereo_top #(
	parameter int LINE_DEPTH = srs_pkg::LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
	parameter int CHANNELS = srs_pkg::CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample_in
	input  logic s_axis_tuser,                              // channel_sel
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata, // sample_out
	output logic m_axis_tuser,                              // channel_out
	input  logic cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [srs_pkg::SPREAD_W-1:0] cfg_wdata
);
	import srs_pkg::*;
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DW = ((SAMPLE_BITS+7)/8)*8;

	logic [GAIN_W-1:0]   gain_q;
	logic [DLY_W-1:0]    dly_q;
	logic [SPREAD_W-1:0] spread_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			dly_q    <= '0;
			spread_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_GAIN:   gain_q   <= cfg_wdata[GAIN_W-1:0];
				REG_DELAY:  dly_q    <= cfg_wdata[DLY_W-1:0];
				REG_SPREAD: spread_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [ALL_LINES-1:0][AW-1:0] delay;
	srs_delay_calc #(.LINE_DEPTH(LINE_DEPTH)) u_dly (
		.clk(clk), .mod_delay(dly_q), .mod_spread(spread_q), .delay(delay));

	logic q_valid, q_ready, q_sel;
	logic [CW-1:0] q_ch;
	logic [SAMPLE_BITS-1:0] q_smp, m_smp;
	srs_front #(.SAMPLE_BITS(SAMPLE_BITS), .CHANNELS(CHANNELS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sel(s_axis_tuser), .smp(s_axis_tdata[SAMPLE_BITS-1:0]),
		.q_valid(q_valid), .q_ready(q_ready), .q_sel(q_sel), .q_ch(q_ch), .q_smp(q_smp));

	srs_back #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .CHANNELS(CHANNELS)) u_back (
		.clk(clk), .arst_n(arst_n), .gain_a(gain_q), .delay(delay),
		.q_valid(q_valid), .q_ready(q_ready), .q_sel(q_sel), .q_ch(q_ch), .q_smp(q_smp),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_sel(m_axis_tuser), .m_smp(m_smp));

	assign m_axis_tdata = DW'(m_smp);
endmodule

>>> rtl/srs_delay_calc.sv
`timescale 1ns / 1ps
module srs_delay_calc #(
	parameter int LINE_DEPTH = srs_pkg::LINE_DEPTH_DEF,
	parameter int AW = $clog2(LINE_DEPTH)
) (
	input  logic                             clk,
	input  logic [srs_pkg::DLY_W-1:0]        mod_delay,
	input  logic [srs_pkg::SPREAD_W-1:0]     mod_spread,
	output logic [srs_pkg::ALL_LINES-1:0][AW-1:0] delay
);
	import srs_pkg::*;
	// D*F registered, then per-line *m, sum and clamp registered
	logic [DLY_W+SPREAD_W-1:0] df_q;
	logic [DLY_W-1:0]          d_q;
	always_ff @(posedge clk) begin
		df_q <= DLY_W'(mod_delay) * SPREAD_W'(mod_spread);
		d_q  <= mod_delay;
	end
	for (genvar k = 0; k < ALL_LINES; k++) begin : g_line
		logic [DLY_W+SPREAD_W+3:0] prod;
		logic [DLY_W+SPREAD_W+3:0] tot;
		assign prod = (DLY_W+SPREAD_W+4)'(df_q) * (DLY_W+SPREAD_W+4)'(line_mult(k));
		assign tot  = (DLY_W+SPREAD_W+4)'(line_base(k)) + (DLY_W+SPREAD_W+4)'(d_q)
			+ (prod >> 12);
		always_ff @(posedge clk) begin
			if (tot > (DLY_W+SPREAD_W+4)'(LINE_DEPTH - 1))
				delay[k] <= AW'(LINE_DEPTH - 1);
			else
				delay[k] <= tot[AW-1:0];
		end
	end
endmodule

>>> rtl/srs_front.sv
`timescale 1ns / 1ps
module srs_front #(
	parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
	parameter int CHANNELS = srs_pkg::CHANNELS_DEF,
	parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   sel,
	input  logic [SAMPLE_BITS-1:0] smp,
	output logic                   q_valid,
	input  logic                   q_ready,
	output logic                   q_sel,
	output logic [CW-1:0]          q_ch,
	output logic [SAMPLE_BITS-1:0] q_smp
);
	// two-entry queue; classifies channel to store index
	logic [1:0]                   v_q;
	logic [1:0]                   sel_q;
	logic [1:0][CW-1:0]           ch_q;
	logic [1:0][SAMPLE_BITS-1:0]  smp_q;
	logic                         rd_q, wr_q;
	logic [CW-1:0]                ch_in;
	logic                         push, pop;

	assign ch_in = (CHANNELS == 1 || !sel) ? CW'(0) : CW'(1);
	assign in_ready = !v_q[wr_q];
	assign q_valid  = v_q[rd_q];
	assign q_sel    = sel_q[rd_q];
	assign q_ch     = ch_q[rd_q];
	assign q_smp    = smp_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) begin
				v_q[wr_q] <= 1'b1;
				wr_q <= !wr_q;
			end
			if (pop) begin
				v_q[rd_q] <= 1'b0;
				rd_q <= !rd_q;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (push) begin
			sel_q[wr_q] <= sel;
			ch_q[wr_q]  <= ch_in;
			smp_q[wr_q] <= smp;
		end
	end
endmodule

>>> rtl/srs_line.sv
`timescale 1ns / 1ps
module srs_line #(
	parameter int LINE_DEPTH = srs_pkg::LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
	parameter int CHANNELS = srs_pkg::CHANNELS_DEF,
	parameter int AW = $clog2(LINE_DEPTH),
	parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clr_en,
	input  logic [CW+AW-1:0]       clr_addr,
	input  logic                   rd_en,
	input  logic [CW-1:0]          ch,
	input  logic [AW-1:0]          dly,
	output logic [SAMPLE_BITS-1:0] rd_data,
	input  logic                   wr_en,
	input  logic [SAMPLE_BITS-1:0] wr_data
);
	// one delay line, all channels; read in cycle A, write in cycle B
	logic [SAMPLE_BITS-1:0] mem [CHANNELS*LINE_DEPTH];
	logic [CHANNELS-1:0][AW-1:0] wp_q;
	logic [AW-1:0] rp;
	logic [CW-1:0] ch_wr_q;

	function automatic logic [CW+AW-1:0] addr(input logic [CW-1:0] c, input logic [AW-1:0] a);
		addr = (CW+AW)'(c) * (CW+AW)'(LINE_DEPTH) + (CW+AW)'(a);
	endfunction

	assign rp = (LINE_DEPTH & (LINE_DEPTH - 1)) == 0 ? AW'(wp_q[ch] - dly) :
		(wp_q[ch] >= dly ? AW'(wp_q[ch] - dly) : AW'(wp_q[ch] + AW'(LINE_DEPTH) - dly));

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[addr(ch, rp)];
			ch_wr_q <= ch;
		end
		if (clr_en)
			mem[clr_addr] <= '0;
		else if (wr_en)
			mem[addr(ch_wr_q, wp_q[ch_wr_q])] <= wr_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wp_q <= '0;
		else if (wr_en && !clr_en)
			wp_q[ch_wr_q] <= (wp_q[ch_wr_q] == AW'(LINE_DEPTH - 1)) ? '0 : AW'(wp_q[ch_wr_q] + 1'b1);
	end
endmodule

>>> rtl/srs_back.sv
`timescale 1ns / 1ps
module srs_back #(
	parameter int LINE_DEPTH = srs_pkg::LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
	parameter int CHANNELS = srs_pkg::CHANNELS_DEF,
	parameter int AW = $clog2(LINE_DEPTH),
	parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [srs_pkg::GAIN_W-1:0] gain_a,
	input  logic [srs_pkg::ALL_LINES-1:0][AW-1:0] delay,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  logic                   q_sel,
	input  logic [CW-1:0]          q_ch,
	input  logic [SAMPLE_BITS-1:0] q_smp,
	output logic                   m_valid,
	input  logic                   m_ready,
	output logic                   m_sel,
	output logic [SAMPLE_BITS-1:0] m_smp
);
	import srs_pkg::*;
	localparam int SB = SAMPLE_BITS;
	localparam int PW = SB + GAIN_W + 2;
	localparam int CLR_N = CHANNELS * LINE_DEPTH;
	localparam int CLW = CW + AW + 1;

	logic [CLW-1:0] clr_q;
	logic clearing;
	assign clearing = clr_q != CLW'(CLR_N);

	// stage k (0..6) handles line k; each item is read in phase A and written in phase B of its stage
	logic [ALL_LINES:0]            v_q;
	logic [ALL_LINES:0]            ph_q;
	logic [ALL_LINES:0]            sel_q;
	logic [ALL_LINES:0][CW-1:0]    ch_q;
	logic [ALL_LINES:0][SB-1:0]    x_q;
	logic [ALL_LINES:0][SB+2:0]    sum_q;
	logic [ALL_LINES-1:0]          adv;
	logic [ALL_LINES-1:0]          rd_en, wr_en;
	logic [ALL_LINES-1:0][SB-1:0]  rdata, wdata, nx;
	logic [ALL_LINES-1:0][SB+2:0]  nsum;
	logic                          out_free;

	function automatic logic signed [SB-1:0] sat(input logic signed [PW:0] v);
		logic signed [PW:0] hi, lo;
		hi = (PW+1)'((64'sd1 <<< (SB - 1)) - 1);
		lo = -hi - 1;
		if (v > hi) sat = SB'(hi);
		else if (v < lo) sat = SB'(lo);
		else sat = SB'(v);
	endfunction

	function automatic logic signed [PW:0] gmul(input logic signed [SB-1:0] x,
		input logic [GAIN_W-1:0] g);
		logic signed [PW:0] p;
		p = (PW+1)'(x) * $signed({1'b0, g}) + (PW+1)'(16384);
		gmul = p >>> 15;
	endfunction

	assign out_free = !m_valid || m_ready;
	// stage k slot free when empty, or in phase B and next stage can take
	logic [ALL_LINES:0] free;
	assign free[ALL_LINES] = !v_q[ALL_LINES] || out_free;
	for (genvar k = ALL_LINES - 1; k >= 0; k--) begin : g_free
		assign free[k] = !v_q[k] || (ph_q[k] && free[k+1]);
	end
	assign q_ready = free[0] && !clearing;

	for (genvar k = 0; k < ALL_LINES; k++) begin : g_stage
		logic signed [SB-1:0] xs, vs;
		assign xs = x_q[k];
		assign vs = rdata[k];
		assign rd_en[k] = v_q[k] && !ph_q[k];
		assign adv[k]   = v_q[k] && ph_q[k] && free[k+1];
		assign wr_en[k] = adv[k];
		if (k < AP_LINES) begin : g_ap
			assign nx[k]    = sat(gmul(xs, gain_a) + (PW+1)'(vs));
			assign wdata[k] = sat((PW+1)'(xs) - gmul(vs, gain_a));
			assign nsum[k]  = sum_q[k];
		end else begin : g_cf
			assign nx[k]    = xs;
			assign wdata[k] = xs;
			assign nsum[k]  = (SB+3)'($signed(sum_q[k]) + (SB+3)'(sat((PW+1)'(xs) + gmul(vs, gain_a))));
		end
		srs_line #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SB), .CHANNELS(CHANNELS)) u_line (
			.clk(clk), .arst_n(arst_n),
			.clr_en(clearing), .clr_addr(clr_q[CW+AW-1:0]),
			.rd_en(rd_en[k]), .ch(ch_q[k]), .dly(delay[k]), .rd_data(rdata[k]),
			.wr_en(wr_en[k]), .wr_data(wdata[k]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			ph_q  <= '0;
			clr_q <= '0;
			m_valid <= 1'b0;
		end else begin
			if (clearing) clr_q <= CLW'(clr_q + 1'b1);
			if (q_valid && q_ready) begin
				v_q[0] <= 1'b1;
				ph_q[0] <= 1'b0;
			end else if (adv[0]) v_q[0] <= 1'b0;
			if (rd_en[0]) ph_q[0] <= 1'b1;
			for (int k = 1; k < ALL_LINES; k++) begin
				if (adv[k-1]) begin
					v_q[k] <= 1'b1;
					ph_q[k] <= 1'b0;
				end else if (adv[k]) v_q[k] <= 1'b0;
				if (rd_en[k]) ph_q[k] <= 1'b1;
			end
			if (adv[ALL_LINES-1]) v_q[ALL_LINES] <= 1'b1;
			else if (free[ALL_LINES]) v_q[ALL_LINES] <= 1'b0;
			if (v_q[ALL_LINES] && out_free) m_valid <= 1'b1;
			else if (m_ready) m_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			sel_q[0] <= q_sel;
			ch_q[0]  <= q_ch;
			x_q[0]   <= q_smp;
			sum_q[0] <= '0;
		end
		for (int k = 1; k <= ALL_LINES; k++) begin
			if (adv[k-1]) begin
				sel_q[k] <= sel_q[k-1];
				ch_q[k]  <= ch_q[k-1];
				x_q[k]   <= nx[k-1];
				sum_q[k] <= nsum[k-1];
			end
		end
		if (v_q[ALL_LINES] && out_free) begin
			m_sel <= sel_q[ALL_LINES];
			m_smp <= SB'(($signed(sum_q[ALL_LINES]) + (SB+3)'(2)) >>> 2);
		end
	end
endmodule
